### rtl/ptns_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptns_pkg
// Shared types, register codes and the MIDI boundary table of the note
// segmenter.
// ---------------------------------------------------------------------------
package ptns_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_MIN_FRAMES = 8'd0;
    localparam logic [7:0] CFG_CONF_DIV   = 8'd1;

    localparam logic [15:0] MIN_FRAMES_RST = 16'd10;
    localparam logic [15:0] CONF_DIV_RST   = 16'd100;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    localparam int NOTE_COUNT = 127;
    localparam logic [63:0] NOTE_SCALE = 64'd1000000000;

    // boundary base values, 110 Hz * 2^(j/24) for odd j, scaled by 1e9
    localparam logic [63:0] BASE_BOUNDARY [12] = '{
        64'd113223246031, 64'd119955850593, 64'd127088796655, 64'd134645889759,
        64'd142652351012, 64'd151134901221, 64'd160121850112, 64'd169643190795,
        64'd179730699857, 64'd190418043417, 64'd201740889505, 64'd213737027052
    };

    typedef logic [31:0] t_thr_tab [NOTE_COUNT];

    // lower boundary of each note 1..127, rounded up to Q12.4 steps
    function automatic t_thr_tab f_build_thr();
        t_thr_tab    tab;
        int          pos;
        int          sh;
        int          sel;
        logic [63:0] v;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            pos = 2 * i + 7;
            sh  = pos / 24;
            sel = ((pos % 24) - 1) / 2;
            v   = ((BASE_BOUNDARY[sel] << sh) + NOTE_SCALE - 64'd1) / NOTE_SCALE;
            tab[i] = v[31:0];
        end
        return tab;
    endfunction

    localparam t_thr_tab MIDI_THR = f_build_thr();

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_MUL_SS,
        OP_MUL_NQLO,
        OP_MUL_NQHI,
        OP_MUL_NN,
        OP_MUL_DEN,
        OP_SUB,
        OP_QCHK,
        OP_QSTEP,
        OP_MSTEP,
        OP_NSTEP,
        OP_LOAD
    } t_dp_op;

    typedef struct packed {
        logic   frame;   // take the input frame this cycle
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;      // the open run is long enough to give a note
        logic voiced;    // the offered frame carries a pitch
    } t_dp_stat;

endpackage
`default_nettype wire

### rtl/ptns_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptns_ctrl
// Sequencer: takes frames, and on a closing frame walks the datapath through
// the multiply, divide and note search steps, then hands the record out.
// ---------------------------------------------------------------------------
module ptns_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  ptns_pkg::t_dp_stat  i_stat,
    output ptns_pkg::t_dp_cmd   o_cmd
);
    import ptns_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SS, S_NQLO, S_NQHI, S_NN, S_DEN, S_SUB,
        S_QCHK, S_QDIV, S_MDIV, S_NOTE, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       load_ok;

    assign load_ok     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd.frame = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_IDLE:  o_cmd.op = OP_IDLE;
            S_SS:    o_cmd.op = OP_MUL_SS;
            S_NQLO:  o_cmd.op = OP_MUL_NQLO;
            S_NQHI:  o_cmd.op = OP_MUL_NQHI;
            S_NN:    o_cmd.op = OP_MUL_NN;
            S_DEN:   o_cmd.op = OP_MUL_DEN;
            S_SUB:   o_cmd.op = OP_SUB;
            S_QCHK:  o_cmd.op = OP_QCHK;
            S_QDIV:  o_cmd.op = OP_QSTEP;
            S_MDIV:  o_cmd.op = OP_MSTEP;
            S_NOTE:  o_cmd.op = OP_NSTEP;
            S_OUT:   o_cmd.op = load_ok ? OP_LOAD : OP_IDLE;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.emit && !i_stat.voiced) n_state = S_SS;
            end
            S_SS:   n_state = S_NQLO;
            S_NQLO: n_state = S_NQHI;
            S_NQHI: n_state = S_NN;
            S_NN:   n_state = S_DEN;
            S_DEN:  n_state = S_SUB;
            S_SUB:  n_state = S_QCHK;
            S_QCHK: begin
                n_state = S_QDIV;
                n_cnt   = 4'd7;
            end
            S_QDIV: begin
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = S_MDIV;
                    n_cnt   = 4'd15;
                end
            end
            S_MDIV: begin
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = S_NOTE;
                    n_cnt   = 4'd6;
                end
            end
            S_NOTE: begin
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) n_state = S_OUT;
            end
            S_OUT: begin
                if (load_ok) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### rtl/ptns_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptns_datapath
// Run accumulators, shared 32x32 multiplier, serial dividers, note search
// and the output record register.
// ---------------------------------------------------------------------------
module ptns_datapath #(
    parameter int FRAME_INDEX_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ptns_pkg::t_dp_cmd   i_cmd,
    output ptns_pkg::t_dp_stat  o_stat,
    input  wire [15:0]          i_pitch,
    input  wire                 i_curve_start,
    input  wire                 i_cfg_we,
    input  wire [7:0]           i_cfg_index,
    input  wire [15:0]          i_cfg_data,
    output logic [15:0]         o_start_frame,
    output logic [15:0]         o_end_frame,
    output logic [15:0]         o_mean_pitch,
    output logic [8:0]          o_confidence,
    output logic [6:0]          o_midi_note
);
    import ptns_pkg::*;

    localparam logic [FRAME_INDEX_BITS-1:0] IDX_MAX = '1;

    // configuration
    logic [15:0] r_min_frames;
    logic [15:0] r_conf_div;

    // run state
    logic                        r_in_run;
    logic [FRAME_INDEX_BITS-1:0] r_idx;
    logic [FRAME_INDEX_BITS-1:0] r_start;
    logic [FRAME_INDEX_BITS-1:0] r_end;
    logic [15:0]                 r_count;
    logic [31:0]                 r_sum;
    logic [47:0]                 r_sq;

    // note computation
    logic [63:0] r_prod, r_ss, r_acc, r_num, r_rem;
    logic [47:0] r_den;
    logic [54:0] r_dsh;
    logic        r_qsat;
    logic [7:0]  r_q;
    logic [31:0] r_mrem;
    logic [30:0] r_mdsh;
    logic [15:0] r_mean;
    logic [6:0]  r_note, r_nbit;

    logic                        eff_run;
    logic [FRAME_INDEX_BITS-1:0] idx;
    logic [31:0]                 pitch_sq;
    logic [31:0]                 mul_a, mul_b;
    logic [15:0]                 div_eff;
    logic [6:0]                  cand, cand_m1;
    logic [31:0]                 start_ext, end_ext;

    assign eff_run = r_in_run && !i_curve_start;
    assign idx     = i_curve_start ? '0 : r_idx;
    assign pitch_sq = 32'(i_pitch) * 32'(i_pitch);
    assign o_stat.voiced = (i_pitch != 16'd0);
    assign o_stat.emit   = eff_run && (r_count >= r_min_frames);
    assign div_eff = (r_conf_div == 16'd0) ? 16'd1 : r_conf_div;
    assign cand    = r_note | r_nbit;
    assign cand_m1 = cand - 7'd1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frames <= MIN_FRAMES_RST;
            r_conf_div   <= CONF_DIV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_FRAMES: r_min_frames <= i_cfg_data;
                CFG_CONF_DIV:   r_conf_div   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame intake and run accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
            r_idx    <= '0;
        end else if (i_cmd.frame) begin
            r_idx <= (idx == IDX_MAX) ? idx : idx + FRAME_INDEX_BITS'(1);
            if (i_pitch != 16'd0) begin
                if (!eff_run) begin
                    r_in_run <= 1'b1;
                    r_start  <= idx;
                    r_count  <= 16'd1;
                    r_sum    <= {16'd0, i_pitch};
                    r_sq     <= {16'd0, pitch_sq};
                end else if (r_count != COUNT_MAX) begin
                    r_count <= r_count + 16'd1;
                    r_sum   <= r_sum + {16'd0, i_pitch};
                    r_sq    <= r_sq + {16'd0, pitch_sq};
                end
            end else begin
                r_in_run <= 1'b0;
                r_end    <= idx;
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_SS:   begin mul_a = r_sum;             mul_b = r_sum;              end
            OP_MUL_NQLO: begin mul_a = {16'd0, r_count};  mul_b = {8'd0, r_sq[23:0]};  end
            OP_MUL_NQHI: begin mul_a = {16'd0, r_count};  mul_b = {8'd0, r_sq[47:24]}; end
            OP_MUL_NN:   begin mul_a = {16'd0, r_count};  mul_b = {16'd0, r_count};   end
            OP_MUL_DEN:  begin mul_a = r_prod[31:0];      mul_b = {16'd0, div_eff};   end
            default: ;
        endcase
    end

    // note sequence: products, variance quotient, mean, note search
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (i_cmd.op)
            OP_MUL_NQLO: r_ss  <= r_prod;
            OP_MUL_NQHI: r_acc <= r_prod;
            OP_MUL_NN:   r_acc <= r_acc + (r_prod << 24);
            OP_SUB: begin
                r_den <= r_prod[47:0];
                r_num <= r_acc - r_ss;
            end
            OP_QCHK: begin
                r_qsat <= (r_num >= {8'd0, r_den, 8'd0});
                r_rem  <= r_num;
                r_dsh  <= {r_den, 7'd0};
                r_q    <= 8'd0;
                r_mrem <= r_sum;
                r_mdsh <= {r_count, 15'd0};
                r_mean <= 16'd0;
                r_note <= 7'd0;
                r_nbit <= 7'b1000000;
            end
            OP_QSTEP: begin
                if (r_rem >= {9'd0, r_dsh}) begin
                    r_rem <= r_rem - {9'd0, r_dsh};
                    r_q   <= {r_q[6:0], 1'b1};
                end else begin
                    r_q   <= {r_q[6:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
            end
            OP_MSTEP: begin
                if (r_mrem >= {1'b0, r_mdsh}) begin
                    r_mrem <= r_mrem - {1'b0, r_mdsh};
                    r_mean <= {r_mean[14:0], 1'b1};
                end else begin
                    r_mean <= {r_mean[14:0], 1'b0};
                end
                r_mdsh <= r_mdsh >> 1;
            end
            OP_NSTEP: begin
                // thresholds rise with note number, so search bit by bit
                if (MIDI_THR[cand_m1] <= {16'd0, r_mean}) r_note <= cand;
                r_nbit <= r_nbit >> 1;
            end
            default: ;
        endcase
    end

    // output record
    assign start_ext = 32'(r_start);
    assign end_ext   = 32'(r_end);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            o_start_frame <= start_ext[15:0];
            o_end_frame   <= end_ext[15:0];
            o_mean_pitch  <= r_mean;
            o_confidence  <= r_qsat ? 9'd0 : 9'd256 - {1'b0, r_q};
            o_midi_note   <= r_note;
        end
    end

endmodule
`default_nettype wire

### rtl/pitch_track_note_segmenter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pitch_track_note_segmenter
// Splits a pitch track into voiced runs and emits one note record per run
// that closes on an unvoiced frame and is long enough.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata pitch, tuser curve start
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata note record
//  cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
//  A frame that closes no note leaves the input ready. A frame that closes a
//  note keeps the input stalled while the note is worked out: 5 passes
//  of the shared multiplier, subtract and range check, 8 quotient steps,
//  16 mean steps and 7 note search steps, then the record loads. The load
//  waits while the previous record is still unread. Reset is synchronous
//  and active low.
// ---------------------------------------------------------------------------
module pitch_track_note_segmenter #(
    parameter int FRAME_INDEX_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [15:0]  i_s_axis_tdata,   // [15:0] frame_pitch
    input  wire [0:0]   i_s_axis_tuser,   // [0] curve_start
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [15:0] start_frame, [31:16] end_frame,
                                          // [47:32] mean_pitch, [56:48] confidence,
                                          // [63:57] midi_note
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [7:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data
);
    import ptns_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ptns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ptns_datapath #(
        .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pitch       (i_s_axis_tdata),
        .i_curve_start (i_s_axis_tuser[0]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_start_frame (o_m_axis_tdata[15:0]),
        .o_end_frame   (o_m_axis_tdata[31:16]),
        .o_mean_pitch  (o_m_axis_tdata[47:32]),
        .o_confidence  (o_m_axis_tdata[56:48]),
        .o_midi_note   (o_m_axis_tdata[63:57])
    );

endmodule
`default_nettype wire
